[rtl/ierf_pkg.sv]
package ierf_pkg;

	localparam int QSIZE_W = 7;
	localparam logic [QSIZE_W-1:0] QSIZE_RESET = 7'd64;
	localparam logic [QSIZE_W-1:0] QSIZE_MIN = 7'd2;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [15:0] SYN_TYPE = 16'd0;
	localparam logic [15:0] SYN_REPORT_CODE = 16'd0;
	localparam logic [15:0] SYN_DROPPED_CODE = 16'd3;

	localparam int EVENT_W = 64;
	localparam int TIME_W = 48;

	typedef struct packed {
		logic               kind;
		logic [15:0]        ev_type;
		logic [15:0]        ev_code;
		logic signed [31:0] ev_value;
		logic [47:0]        timestamp;
	} ierf_in_t;

	typedef struct packed {
		logic               overflowed;
		logic               read_valid;
		logic [15:0]        out_type;
		logic [15:0]        out_code;
		logic signed [31:0] out_value;
		logic [47:0]        out_time;
	} ierf_out_t;

endpackage

[rtl/ierf_ram.sv]
module ierf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/input_event_report_fifo_unit.sv]
// Channel   Handshake                 Payload
// item      start / busy              ierf_in_t (kind, type, code, value, timestamp)
// result    done (one-cycle strobe)   ierf_out_t (overflowed, read_valid, entry fields)
// config    cfg_valid / cfg_ready     cfg_data (queue size, clamped to 2..DEPTH)
//
// A push holds busy through the WRITE state, with MARK first when the ring is full.
// A report end adds the STAMP state, one time RAM write per entry stamped.
// A read holds busy through READ and RDATA (event and time RAM read); an empty read
// raises done in the cycle after start with busy staying low.
// done comes in the first cycle with busy low; the next start is taken in that cycle.
// Reset empties the ring and sets the queue size to 64; RAM contents stay unknown.
module input_event_report_fifo_unit #(
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  ierf_pkg::ierf_in_t                    item,
	output logic                                  done,
	output ierf_pkg::ierf_out_t                   result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ierf_pkg::QSIZE_W-1:0]          cfg_data
);

	import ierf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MARK  = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_STAMP = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_RDATA = 3'd5;

	logic [2:0]         state_q;
	logic [QSIZE_W-1:0] qsize_q;
	logic [PW-1:0]      wp_q, rp_q, ep_q;
	logic               ovf_q, done_q;
	ierf_in_t           item_q;
	ierf_out_t          result_q, res_d;

	logic [NW-1:0]      ring_n;
	logic [PW-1:0]      wp_inc, rp_inc, ep_inc, mark;
	logic               full, is_report, finish, accept;

	logic               ev_we, ev_re;
	logic [PW-1:0]      ev_waddr;
	logic [EVENT_W-1:0] ev_wdata, ev_rdata;
	logic               tm_we;
	logic [TIME_W-1:0]  tm_rdata;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [NW-1:0] n);
		logic [NW:0] nx;
		nx = (NW+1)'(p) + 1'b1;
		return (nx == (NW+1)'(n)) ? '0 : PW'(nx);
	endfunction

	always_comb begin
		if (qsize_q < QSIZE_MIN) begin
			ring_n = NW'(QSIZE_MIN);
		end else if (32'(qsize_q) > 32'(DEPTH)) begin
			ring_n = NW'(DEPTH);
		end else begin
			ring_n = NW'(qsize_q);
		end
	end

	assign wp_inc = ptr_inc(wp_q, ring_n);
	assign rp_inc = ptr_inc(rp_q, ring_n);
	assign ep_inc = ptr_inc(ep_q, ring_n);
	assign mark = (wp_q == '0) ? PW'(ring_n - 1'b1) : wp_q - 1'b1;
	assign full = (wp_inc == rp_q);
	assign is_report = (item_q.ev_type == SYN_TYPE) && (item_q.ev_code == SYN_REPORT_CODE);

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = !busy && !start;

	assign ev_we = (state_q == S_MARK) || (state_q == S_WRITE);
	assign ev_waddr = (state_q == S_MARK) ? mark : wp_q;
	assign ev_wdata = (state_q == S_MARK) ? {SYN_TYPE, SYN_DROPPED_CODE, 32'd0}
		: {item_q.ev_type, item_q.ev_code, item_q.ev_value};
	assign ev_re = (state_q == S_READ);
	assign tm_we = (state_q == S_STAMP) && (ep_q != wp_q);

	ierf_ram #(.WIDTH(EVENT_W), .DEPTH(DEPTH)) u_event_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.re    (ev_re),
		.raddr (rp_q),
		.rdata (ev_rdata)
	);

	ierf_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (tm_we),
		.waddr (ep_q),
		.wdata (item_q.timestamp),
		.re    (ev_re),
		.raddr (rp_q),
		.rdata (tm_rdata)
	);

	always_comb begin
		finish = 1'b0;
		unique case (state_q)
			S_IDLE:  finish = accept && (item.kind == KIND_READ) && (rp_q == ep_q);
			S_WRITE: finish = !is_report;
			S_STAMP: finish = (ep_q == wp_q);
			S_RDATA: finish = 1'b1;
			default: finish = 1'b0;
		endcase
	end

	always_comb begin
		res_d = '0;
		if (state_q == S_RDATA) begin
			res_d.read_valid = 1'b1;
			res_d.out_type = ev_rdata[63:48];
			res_d.out_code = ev_rdata[47:32];
			res_d.out_value = ev_rdata[31:0];
			res_d.out_time = tm_rdata;
		end else if (state_q != S_IDLE) begin
			res_d.overflowed = ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			qsize_q <= QSIZE_RESET;
			wp_q <= '0;
			rp_q <= '0;
			ep_q <= '0;
			ovf_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (cfg_valid && cfg_ready) begin
				qsize_q <= cfg_data;
				wp_q <= '0;
				rp_q <= '0;
				ep_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ovf_q <= 1'b0;
						if (item.kind == KIND_PUSH) begin
							state_q <= full ? S_MARK : S_WRITE;
						end else if (rp_q != ep_q) begin
							state_q <= S_READ;
						end
					end
				end
				S_MARK: begin
					// drop unread content, keep only the marker
					rp_q <= mark;
					ep_q <= mark;
					ovf_q <= 1'b1;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					wp_q <= wp_inc;
					state_q <= is_report ? S_STAMP : S_IDLE;
				end
				S_STAMP: begin
					// advance the ready pointer one stamped entry a cycle
					if (ep_q != wp_q) begin
						ep_q <= ep_inc;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					rp_q <= rp_inc;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (finish) begin
			result_q <= res_d;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[rtl/ierf_check.sv]
module ierf_check (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input ierf_pkg::ierf_out_t result
);

	import ierf_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat shown while busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither worked on nor answered");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.overflowed && result.read_valid))
		else $error("result beat is both overflow and read");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.read_valid) |-> (result.out_type == '0 && result.out_code == '0
			&& result.out_value == '0 && result.out_time == '0))
		else $error("result beat without read data carries entry fields");

endmodule

bind input_event_report_fifo_unit ierf_check u_ierf_check (.*);
